// ===== sv/negacyclic_poly_mul_mod_q_defines.svh =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NEGACYCLIC_POLY_MUL_MOD_Q_DEFINES_SVH
`define NEGACYCLIC_POLY_MUL_MOD_Q_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define NMQ_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define NMQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/nmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier package
// Sizes, modulus constants, state codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package nmq_pkg;

  localparam int unsigned DEGREE  = 128;
  localparam int unsigned IDX_W   = (DEGREE > 1) ? $clog2(DEGREE) : 1;
  localparam int unsigned IN_W    = 31;
  localparam int unsigned COEF_W  = 30;
  localparam int unsigned PROD_W  = 2 * COEF_W;
  localparam int unsigned TDATA_W = 64;

  // Modulus and its fold constant: 2^30 = FOLD (mod Q).
  localparam logic [COEF_W-1:0] MOD_Q = 30'd1073643521;
  localparam logic [COEF_W-1:0] FOLD  = COEF_W'((64'd1 << COEF_W) - 64'(MOD_Q));

  // Widths of the three folding stages.
  localparam int unsigned F1_W = 48;
  localparam int unsigned F2_W = 36;
  localparam int unsigned F3_W = 31;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CALC,
    ST_DRAIN
  } nmq_state_e;

  // Tag that travels with one product term down the pipeline.
  typedef struct packed {
    logic valid;
    logic first;     // first term of a coefficient: restart the sum
    logic lastk;     // last term of a coefficient
    logic neg;       // wrapped index: subtract
    logic odd_slot;  // coefficient goes to the odd half of a pair
    logic pair_end;  // coefficient closes a result pair
    logic tail;      // closes the final pair of the product
  } nmq_tag_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
    nmq_tag_t         tag;
  } nmq_cmd_t;

  typedef struct packed {
    logic out_fire;
  } nmq_sts_t;

endpackage

`default_nettype wire

// ===== sv/nmq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nmq_ram #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/nmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier controller
// Counts operand loads, then walks every (coefficient, term) pair and issues
// one product term per cycle to the datapath, except while a pair-closing term is held.
// ----------------------------------------------------------------------------
`default_nettype none

module nmq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output nmq_pkg::nmq_cmd_t      cmd_o,
  input  wire nmq_pkg::nmq_sts_t sts_i
);

  localparam logic [nmq_pkg::IDX_W-1:0] LAST_IDX = nmq_pkg::IDX_W'(nmq_pkg::DEGREE - 1);

  nmq_pkg::nmq_state_e        state_q, state_d;
  logic [nmq_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  logic [nmq_pkg::IDX_W-1:0]  k_q, k_d;
  logic [nmq_pkg::IDX_W-1:0]  i_q, i_d;
  logic                       pend_q, pend_d;

  logic                       neg;
  logic [nmq_pkg::IDX_W:0]    j_wide;
  logic                       pair_end;
  logic                       last_term;
  logic                       hold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nmq_pkg::ST_LOAD;
      cnt_q   <= '0;
      k_q     <= '0;
      i_q     <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      i_q     <= i_d;
      pend_q  <= pend_d;
    end
  end

  // Term a[i]*b[j] with i+j = k, or i+j = k+N when it wraps.
  assign neg       = (i_q > k_q);
  assign j_wide    = {1'b0, k_q} - {1'b0, i_q}
                   + (neg ? (nmq_pkg::IDX_W + 1)'(nmq_pkg::DEGREE) : '0);
  assign pair_end  = k_q[0] || (k_q == LAST_IDX);
  assign last_term = (i_q == LAST_IDX) && pair_end;
  // A pair may only close once the previous pair has left the output register.
  assign hold      = last_term && pend_q;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    i_d        = i_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.waddr  = cnt_q;
    cmd_o.a_addr = i_q;
    cmd_o.b_addr = j_wide[nmq_pkg::IDX_W-1:0];

    if (sts_i.out_fire) begin
      pend_d = 1'b0;
    end

    case (state_q)
      nmq_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.we = 1'b1;
          if (cnt_q == LAST_IDX) begin
            cnt_d   = '0;
            k_d     = '0;
            i_d     = '0;
            state_d = nmq_pkg::ST_CALC;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end

      nmq_pkg::ST_CALC: begin
        if (!hold) begin
          cmd_o.tag.valid    = 1'b1;
          cmd_o.tag.first    = (i_q == '0);
          cmd_o.tag.lastk    = (i_q == LAST_IDX);
          cmd_o.tag.neg      = neg;
          cmd_o.tag.odd_slot = k_q[0];
          cmd_o.tag.pair_end = last_term;
          cmd_o.tag.tail     = (i_q == LAST_IDX) && (k_q == LAST_IDX);
          if (last_term) begin
            pend_d = 1'b1;
          end
          if (i_q == LAST_IDX) begin
            i_d = '0;
            if (k_q == LAST_IDX) begin
              state_d = nmq_pkg::ST_DRAIN;
            end else begin
              k_d = k_q + 1'b1;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end

      nmq_pkg::ST_DRAIN: begin
        // Wait for the final pair to be taken.
        if (!pend_q) begin
          state_d = nmq_pkg::ST_LOAD;
        end
      end

      default: begin
        state_d = nmq_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/nmq_dpath.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier datapath
// Operand stores, pipelined modular multiplier with constant folding,
// modular accumulator and the result pair register.
// ----------------------------------------------------------------------------
`default_nettype none

module nmq_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nmq_pkg::nmq_cmd_t             cmd_i,
  input  wire logic [nmq_pkg::IN_W-1:0]      a_coef_i,
  input  wire logic [nmq_pkg::IN_W-1:0]      b_coef_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [nmq_pkg::COEF_W-1:0]    coef_even_o,
  output logic      [nmq_pkg::COEF_W-1:0]    coef_odd_o,
  output logic                               last_o,
  output nmq_pkg::nmq_sts_t                  sts_o
);

  // Signed 31-bit coefficient to its residue in [0, Q).
  function automatic logic [nmq_pkg::COEF_W-1:0] to_residue(
    input logic [nmq_pkg::IN_W-1:0] x
  );
    logic [nmq_pkg::IN_W-1:0]   mag;
    logic [nmq_pkg::IN_W-1:0]   m;
    logic [nmq_pkg::COEF_W-1:0] red;
    mag = x[nmq_pkg::IN_W-1] ? (~x + 1'b1) : x;
    m   = (mag >= nmq_pkg::IN_W'(nmq_pkg::MOD_Q)) ? (mag - nmq_pkg::IN_W'(nmq_pkg::MOD_Q))
                                                  : mag;
    red = m[nmq_pkg::COEF_W-1:0];
    if (x[nmq_pkg::IN_W-1] && (red != '0)) begin
      return nmq_pkg::MOD_Q - red;
    end
    return red;
  endfunction

  logic [nmq_pkg::COEF_W-1:0] a_res, b_res;
  logic [nmq_pkg::COEF_W-1:0] a_rd, b_rd;

  assign a_res = to_residue(a_coef_i);
  assign b_res = to_residue(b_coef_i);

  nmq_ram #(
    .WIDTH (nmq_pkg::COEF_W),
    .DEPTH (nmq_pkg::DEGREE)
  ) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (a_res),
    .raddr_i (cmd_i.a_addr),
    .rdata_o (a_rd)
  );

  nmq_ram #(
    .WIDTH (nmq_pkg::COEF_W),
    .DEPTH (nmq_pkg::DEGREE)
  ) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (cmd_i.waddr),
    .wdata_i (b_res),
    .raddr_i (cmd_i.b_addr),
    .rdata_o (b_rd)
  );

  nmq_pkg::nmq_tag_t t1_q, t2_q, t3_q, t4_q, t5_q;

  logic [nmq_pkg::PROD_W-1:0] p_q;
  logic [nmq_pkg::F1_W-1:0]   f1_d, f1_q;
  logic [nmq_pkg::F2_W-1:0]   f2_d, f2_q;
  logic [nmq_pkg::F3_W-1:0]   f3;
  logic [nmq_pkg::COEF_W-1:0] r_d, r_q;

  logic [nmq_pkg::COEF_W-1:0] acc_q, acc_d;
  logic [nmq_pkg::COEF_W-1:0] base;
  logic [nmq_pkg::COEF_W:0]   sum;
  logic [nmq_pkg::COEF_W-1:0] even_q;

  logic                       out_valid_q;
  logic [nmq_pkg::COEF_W-1:0] out_even_q, out_odd_q;
  logic                       out_last_q;
  logic                       out_fire;

  // Fold the high half back in three times: 2^30 = FOLD (mod Q).
  assign f1_d = nmq_pkg::F1_W'(p_q[nmq_pkg::PROD_W-1:nmq_pkg::COEF_W])
              * nmq_pkg::F1_W'(nmq_pkg::FOLD)
              + nmq_pkg::F1_W'(p_q[nmq_pkg::COEF_W-1:0]);
  assign f2_d = nmq_pkg::F2_W'(f1_q[nmq_pkg::F1_W-1:nmq_pkg::COEF_W])
              * nmq_pkg::F2_W'(nmq_pkg::FOLD)
              + nmq_pkg::F2_W'(f1_q[nmq_pkg::COEF_W-1:0]);
  assign f3   = nmq_pkg::F3_W'(f2_q[nmq_pkg::F2_W-1:nmq_pkg::COEF_W])
              * nmq_pkg::F3_W'(nmq_pkg::FOLD)
              + nmq_pkg::F3_W'(f2_q[nmq_pkg::COEF_W-1:0]);
  assign r_d  = (f3 >= nmq_pkg::F3_W'(nmq_pkg::MOD_Q))
              ? nmq_pkg::COEF_W'(f3 - nmq_pkg::F3_W'(nmq_pkg::MOD_Q))
              : f3[nmq_pkg::COEF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
      t3_q <= '0;
      t4_q <= '0;
      t5_q <= '0;
    end else begin
      t1_q <= cmd_i.tag;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      t5_q <= t4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= nmq_pkg::PROD_W'(a_rd) * nmq_pkg::PROD_W'(b_rd);
    f1_q <= f1_d;
    f2_q <= f2_d;
    r_q  <= r_d;
  end

  // Modular add or subtract of one term into the running coefficient.
  always_comb begin
    base = t5_q.first ? '0 : acc_q;
    if (t5_q.neg) begin
      sum = (base >= r_q) ? ({1'b0, base} - {1'b0, r_q})
                          : ({1'b0, base} + {1'b0, nmq_pkg::MOD_Q} - {1'b0, r_q});
    end else begin
      sum = {1'b0, base} + {1'b0, r_q};
      if (sum >= {1'b0, nmq_pkg::MOD_Q}) begin
        sum = sum - {1'b0, nmq_pkg::MOD_Q};
      end
    end
    acc_d = sum[nmq_pkg::COEF_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (t5_q.valid) begin
      acc_q <= acc_d;
      if (t5_q.lastk && !t5_q.odd_slot) begin
        even_q <= acc_d;
      end
      if (t5_q.pair_end) begin
        out_even_q <= t5_q.odd_slot ? even_q : acc_d;
        out_odd_q  <= t5_q.odd_slot ? acc_d : '0;
        out_last_q <= t5_q.tail;
      end
    end
  end

  assign out_fire = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (t5_q.valid && t5_q.pair_end) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coef_even_o    = out_even_q;
  assign coef_odd_o     = out_odd_q;
  assign last_o         = out_last_q;
  assign sts_o.out_fire = out_fire;

endmodule

`default_nettype wire

// ===== sv/negacyclic_poly_mul_mod_q.sv =====
// ----------------------------------------------------------------------------
// Negacyclic polynomial multiplier mod Q
// Schoolbook product of two 128-coefficient polynomials in Z_Q[x]/(x^128 + 1).
//
//   channel   dir  tdata (low bit up)                tuser/tlast
//   s_axis    in   a_coef[30:0], b_coef[61:31]       -
//   m_axis    out  coef_even[29:0], coef_odd[59:30]  tlast = last pair
//
// Loading takes 128 items per operand pair.
// The 128th item starts a compute of 128*128 terms on the single
// multiply-accumulate pipeline (one term per cycle unless a stall holds it).
// 64 result pairs leave during the compute; a pair not taken stalls the
// issue of the next pair's closing term. No input is taken during compute.
// Reset clears control only; operand stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module negacyclic_poly_mul_mod_q (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // a_coef [30:0], b_coef [61:31], zero fill [63:62]
  input  wire logic [nmq_pkg::TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // coef_even [29:0], coef_odd [59:30], zero fill [63:60]
  output logic      [nmq_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  nmq_pkg::nmq_cmd_t          cmd;
  nmq_pkg::nmq_sts_t          sts;
  logic [nmq_pkg::COEF_W-1:0] coef_even, coef_odd;

  nmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  nmq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .a_coef_i    (s_axis_tdata[nmq_pkg::IN_W-1:0]),
    .b_coef_i    (s_axis_tdata[2*nmq_pkg::IN_W-1:nmq_pkg::IN_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .coef_even_o (coef_even),
    .coef_odd_o  (coef_odd),
    .last_o      (m_axis_tlast),
    .sts_o       (sts)
  );

  assign m_axis_tdata = nmq_pkg::TDATA_W'({coef_odd, coef_even});

endmodule

`default_nettype wire

// ===== sv/nmq_chk.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "negacyclic_poly_mul_mod_q_defines.svh"

module nmq_chk (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic [nmq_pkg::TDATA_W-1:0] s_axis_tdata,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [nmq_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic                        m_axis_tlast
);

  logic s_fire;
  logic m_tail_fire;

  assign s_fire      = s_axis_tvalid && s_axis_tready;
  assign m_tail_fire = m_axis_tvalid && m_axis_tready && m_axis_tlast;

  `NMQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  `NMQ_ASSERT(a_coef_range, clk_i, rst_ni, !m_axis_tvalid || ((m_axis_tdata[29:0] < nmq_pkg::MOD_Q) && (m_axis_tdata[59:30] < nmq_pkg::MOD_Q) && (m_axis_tdata[63:60] == 4'd0)), "result coefficient out of range")

  `NMQ_ASSERT(a_no_load_while_out, clk_i, rst_ni, !(m_axis_tvalid && s_fire), "operand taken while a result is pending")

  `NMQ_ASSERT_NEXT(a_reload_after_tail, clk_i, rst_ni, m_tail_fire, ##1 s_axis_tready, "not ready for operands after final pair")

endmodule

bind negacyclic_poly_mul_mod_q nmq_chk u_nmq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/nmq_product_checker.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier product checker
// Watches both stream channels, keeps its own copy of the two operand stores,
// computes the full negacyclic product mod Q when the last coefficient pair
// is loaded and compares each result pair, field by field, in order.
// ----------------------------------------------------------------------------
module nmq_product_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // a_coef [30:0], b_coef [61:31], zero fill [63:62]
  input  logic [nmq_pkg::TDATA_W-1:0]    s_tdata_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // coef_even [29:0], coef_odd [59:30], zero fill [63:60]
  input  logic [nmq_pkg::TDATA_W-1:0]    m_tdata_i,
  input  logic                           m_tlast_i,
  output int                             fail_count_o,
  output int                             backlog_o
);

  localparam int unsigned N = nmq_pkg::DEGREE;
  localparam longint MODULUS = longint'(nmq_pkg::MOD_Q);

  typedef struct packed {
    logic [nmq_pkg::COEF_W-1:0] even;
    logic [nmq_pkg::COEF_W-1:0] odd;
    logic                       last;
  } coef_pair_t;

  logic [nmq_pkg::IN_W-1:0] a_coefs [N];
  logic [nmq_pkg::IN_W-1:0] b_coefs [N];
  coef_pair_t               product_pairs [$];
  int                       load_idx;
  int                       mismatches;

  assign fail_count_o = mismatches;

  // Sign-extend a raw 31-bit coefficient and bring it into [0, Q).
  function automatic longint residue(input logic [nmq_pkg::IN_W-1:0] raw);
    longint v;
    v = longint'($signed(raw)) % MODULUS;
    if (v < 0) v += MODULUS;
    return v;
  endfunction

  // Schoolbook product; wrapped terms are subtracted.
  task automatic queue_product_pairs();
    longint     acc [N];
    longint     ai;
    longint     term;
    int         k;
    coef_pair_t pair;
    for (int i = 0; i < N; i++) acc[i] = 0;
    for (int i = 0; i < N; i++) begin
      ai = residue(a_coefs[i]);
      for (int j = 0; j < N; j++) begin
        term = (ai * residue(b_coefs[j])) % MODULUS;
        k = i + j;
        if (k < N) begin
          acc[k] = (acc[k] + term) % MODULUS;
        end else begin
          acc[k - N] = (acc[k - N] + MODULUS - term) % MODULUS;
        end
      end
    end
    for (int m = 0; m < (N + 1) / 2; m++) begin
      pair.even = acc[2 * m][nmq_pkg::COEF_W-1:0];
      pair.odd  = (2 * m + 1 < N) ? acc[2 * m + 1][nmq_pkg::COEF_W-1:0] : '0;
      pair.last = (m + 1 == (N + 1) / 2);
      product_pairs.push_back(pair);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coef_pair_t want;
    coef_pair_t got;
    if (!rst_ni) begin
      load_idx = 0;
      mismatches = 0;
      product_pairs.delete();
      backlog_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.even = m_tdata_i[nmq_pkg::COEF_W-1:0];
        got.odd  = m_tdata_i[2*nmq_pkg::COEF_W-1:nmq_pkg::COEF_W];
        got.last = m_tlast_i;
        if (product_pairs.size() == 0) begin
          $display("%0t: unexpected result pair: expected none, actual even %0d odd %0d last %0b",
                   $time, got.even, got.odd, got.last);
          mismatches++;
        end else begin
          want = product_pairs.pop_front();
          if (got.even !== want.even) begin
            $display("%0t: coef_even mismatch: expected %0d, actual %0d",
                     $time, want.even, got.even);
            mismatches++;
          end
          if (got.odd !== want.odd) begin
            $display("%0t: coef_odd mismatch: expected %0d, actual %0d",
                     $time, want.odd, got.odd);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
            mismatches++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        a_coefs[load_idx] = s_tdata_i[nmq_pkg::IN_W-1:0];
        b_coefs[load_idx] = s_tdata_i[2*nmq_pkg::IN_W-1:nmq_pkg::IN_W];
        load_idx++;
        if (load_idx == N) begin
          queue_product_pairs();
          load_idx = 0;
        end
      end
      backlog_o = product_pairs.size();
    end
  end

endmodule

// ===== tb/tb_negacyclic_poly_mul_mod_q.sv =====
// ----------------------------------------------------------------------------
// Negacyclic multiplier testbench
// Loads operand pairs (directed extremes, full 31-bit patterns, in-range and
// boundary-heavy coefficients) with random gaps on both stream sides and a
// long output hold-off, and lets the product checker judge every result.
// ----------------------------------------------------------------------------
module tb_negacyclic_poly_mul_mod_q;

  localparam int unsigned N = nmq_pkg::DEGREE;
  localparam longint MODULUS = longint'(nmq_pkg::MOD_Q);
  localparam int EXTRA_ITEMS = 4;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  localparam logic [30:0] C_MAX = 31'h3FFF_FFFF;
  localparam logic [30:0] C_MIN = 31'h4000_0000;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [nmq_pkg::TDATA_W-1:0]  s_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [nmq_pkg::TDATA_W-1:0]  m_axis_tdata;
  logic                         m_axis_tlast;
  int                           fail_count;
  int                           backlog;
  int                           pairs_taken;
  int                           quiet_cycles;
  bit                           hold_done;

  negacyclic_poly_mul_mod_q dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  nmq_product_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .fail_count_o(fail_count),
    .backlog_o   (backlog)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Count taken pairs and cycles with no transfer on either side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_taken <= 0;
      quiet_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) pairs_taken <= pairs_taken + 1;
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off while a product drains
  // and the next operands are waiting, plus a window with no gaps.
  initial begin
    m_axis_tready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && pairs_taken >= 20) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (pairs_taken >= 32 && pairs_taken < 56) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  // Offer one coefficient pair and hold it until taken.
  task automatic send_coefs(input logic [30:0] a, input logic [30:0] b, input bit no_gaps);
    while (!no_gaps && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [30:0] in_range_coef();
    longint v;
    v = longint'($urandom_range(32'(2 * (MODULUS - 1)))) - (MODULUS - 1);
    return v[30:0];
  endfunction

  function automatic logic [30:0] boundary_coef();
    logic [30:0] v;
    case ($urandom_range(7))
      0: v = C_MAX;
      1: v = C_MIN;
      2: v = '0;
      3: v = 31'(MODULUS - 1);
      4: v = 31'(-(MODULUS - 1));
      5: v = 31'(MODULUS);
      6: v = 31'($urandom_range(3)) - 31'd1;
      default: v = 31'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    logic [30:0] edge_a [24];
    logic [30:0] edge_b [24];
    logic [30:0] a;
    logic [30:0] b;
    edge_a = '{31'd0, 31'd1, -31'sd1, C_MAX, C_MIN, C_MAX, C_MIN,
               31'(MODULUS - 1), 31'(-(MODULUS - 1)), 31'(MODULUS), 31'(-MODULUS),
               31'(MODULUS + 1), 31'(-(MODULUS + 1)), 31'h2AAA_AAAA, 31'h5555_5555,
               31'd1, 31'd0, C_MAX, 31'h7FFF_FFFF, 31'd2, 31'(MODULUS - 1),
               C_MIN, 31'h0001_8000, 31'h7FFE_8000};
    edge_b = '{31'd0, 31'd1, -31'sd1, C_MAX, C_MIN, C_MIN, C_MAX,
               31'(-(MODULUS - 1)), 31'(MODULUS - 1), 31'(-MODULUS), 31'(MODULUS),
               31'(-(MODULUS + 1)), 31'(MODULUS + 1), 31'h5555_5555, 31'h2AAA_AAAA,
               -31'sd1, C_MAX, 31'd0, 31'd1, 31'(MODULUS - 1), 31'd2,
               31'(MODULUS - 1), 31'h7FFE_8000, 31'h0001_8000};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // One full operand pair, then a few loads of the next pair that wait
    // at the input while the product is computed and drained.
    for (int i = 0; i < N + EXTRA_ITEMS; i++) begin
      if (i < 24) begin
        // Extremes and wrap cases first.
        a = edge_a[i];
        b = edge_b[i];
      end else begin
        case ($urandom_range(2))
          0: begin
            a = 31'($urandom);
            b = 31'($urandom);
          end
          1: begin
            a = in_range_coef();
            b = in_range_coef();
          end
          default: begin
            a = boundary_coef();
            b = boundary_coef();
          end
        endcase
      end
      send_coefs(a, b, (i >= 40 && i < 100));
    end
    s_axis_tvalid <= 1'b0;

    while (backlog != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/nmq_pkg.sv
sv/nmq_ram.sv
sv/nmq_ctrl.sv
sv/nmq_dpath.sv
sv/negacyclic_poly_mul_mod_q.sv
sv/nmq_chk.sv
tb/nmq_product_checker.sv
tb/tb_negacyclic_poly_mul_mod_q.sv
